// ===== rtl/kcm_pkg.sv =====
// Shared types, constants and the white-mode color table for the knob to LED color mapper.
`timescale 1ns / 1ps

package kcm_pkg;

   // Field widths
   localparam int KNOB_W  = 10;
   localparam int COLOR_W = 8;
   localparam int RGB_W   = 3 * COLOR_W;
   localparam int PROD_W  = 18;

   // Table and queue sizes
   localparam int ROM_DEPTH   = 1024;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_FLOOR   = 1'b0;
   localparam logic [0:0] CSR_CEILING = 1'b1;
   localparam logic [COLOR_W-1:0] FLOOR_RESET   = 8'd64;
   localparam logic [COLOR_W-1:0] CEILING_RESET = 8'd255;

   // Hue wheel: 6v spans six sectors of 1023 steps each
   localparam logic [12:0] HUE_STEP  = 13'd1023;
   localparam logic [12:0] HUE_TWO   = 13'd2046;
   localparam logic [12:0] HUE_THREE = 13'd3069;
   localparam logic [12:0] HUE_FOUR  = 13'd4092;
   localparam logic [12:0] HUE_FIVE  = 13'd5115;
   localparam logic [12:0] HUE_SIX   = 13'd6138;
   localparam logic [KNOB_W-1:0] KNOB_MAX = 10'd1023;
   localparam logic [COLOR_W-1:0] FULL_ON  = 8'd255;
   localparam logic [COLOR_W-1:0] FULL_OFF = 8'd0;

   // floor(n / 1023) for n up to 1023*255, as n * ceil(2^28 / 1023) >> 28
   localparam logic [18:0] RECIP_1023  = 19'd262401;
   localparam int          RECIP_SHIFT = 28;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } sector_type;

   // Classified item, as it waits between front and back
   typedef struct packed {
      logic               white_mode;
      logic [KNOB_W-1:0]  color_knob;
      sector_type         sector;
      logic [KNOB_W-1:0]  ramp_base;
      logic [PROD_W-1:0]  level_prod;
      logic               level_neg;
      logic [COLOR_W-1:0] level_floor;
   } front_item_type;

   typedef logic [RGB_W-1:0] white_rom_type [ROM_DEPTH];

   function automatic logic [COLOR_W-1:0] div_by_1023(input logic [PROD_W-1:0] n);
      logic [36:0] p;
      p = {19'd0, n} * {18'd0, RECIP_1023};
      return p[RECIP_SHIFT+COLOR_W-1:RECIP_SHIFT];
   endfunction

   // ------------------------------------------------------------------
   // Q.44 fixed point used to fill the color temperature table at
   // elaboration. Products and quotients truncate.
   // ------------------------------------------------------------------
   localparam int          FRAC  = 44;
   localparam logic [63:0] Q_ONE = 64'd1 << FRAC;
   localparam logic [63:0] DEC   = 64'd10000000000;

   function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[FRAC+63:FRAC];
   endfunction

   // Restoring long division, one quotient bit a step
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          i;
      rem = '0;
      quo = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // floor(num * 2^44 / den)
   function automatic logic [63:0] q_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      int          i;
      q = long_div(num, den);
      r = num - q * den;
      for (i = 0; i < FRAC; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r    = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // 2*atanh(z); stop once the series term has run out of bits
   function automatic logic [63:0] atanh2(input logic [63:0] z);
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] k;
      z2   = q_mul(z, z);
      term = z;
      sum  = '0;
      k    = 64'd1;
      while (k < 64'd80 && term != 64'd0) begin
         sum  = sum + long_div(term, k);
         term = q_mul(term, z2);
         k    = k + 64'd2;
      end
      return sum << 1;
   endfunction

   // ln(a/b) for a >= b > 0
   function automatic logic [63:0] ln_rat(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] ln2);
      logic [63:0] big;
      logic [63:0] k;
      big = b;
      k   = '0;
      while (a >= (big << 1)) begin
         big = big << 1;
         k   = k + 64'd1;
      end
      return k * ln2 + atanh2(q_div(a - big, a + big));
   endfunction

   // exp(-y) by its Taylor series
   function automatic logic [63:0] exp_neg(input logic [63:0] y);
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] k;
      term = Q_ONE;
      pos  = Q_ONE;
      neg  = '0;
      k    = 64'd1;
      while (k < 64'd40 && term != 64'd0) begin
         term = long_div(q_mul(term, y), k);
         if (k[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
         k = k + 64'd1;
      end
      return pos - neg;
   endfunction

   function automatic logic [COLOR_W-1:0] to_byte(input logic [63:0] val);
      logic [COLOR_W-1:0] res;
      if (val >= 64'd255 * Q_ONE) begin
         res = FULL_ON;
      end else begin
         res = val[FRAC+COLOR_W-1:FRAC];
      end
      return res;
   endfunction

   function automatic logic [COLOR_W-1:0] sub_clamp(input logic [63:0] val,
                                                    input logic [63:0] k);
      logic [COLOR_W-1:0] res;
      if (val <= k) begin
         res = FULL_OFF;
      end else begin
         res = to_byte(val - k);
      end
      return res;
   endfunction

   function automatic logic [63:0] pow_part(input logic [63:0] c, input logic [63:0] p,
                                            input logic [63:0] a, input logic [63:0] ln2);
      return q_mul(c, exp_neg(q_mul(p, ln_rat(a, 64'd1023, ln2))));
   endfunction

   // Red, green and blue bytes for color temperatures 1000 K .. 8000 K
   function automatic white_rom_type build_white_rom();
      white_rom_type      rom;
      logic [63:0]        c_r, p_r, c_g1, k_g, c_g2, p_g, c_b, k_b, ln2;
      logic [63:0]        t70, tnum;
      logic [COLOR_W-1:0] r, g, b;
      int                 v;
      c_r  = q_div(64'd3296987274460, DEC);
      p_r  = q_div(64'd1332047592, DEC);
      c_g1 = q_div(64'd994708025861, DEC);
      k_g  = q_div(64'd1611195681661, DEC);
      c_g2 = q_div(64'd2881221695283, DEC);
      p_g  = q_div(64'd755148492, DEC);
      c_b  = q_div(64'd1385177312231, DEC);
      k_b  = q_div(64'd3050447927307, DEC);
      ln2  = atanh2(q_div(64'd1, 64'd3));
      for (v = 0; v < ROM_DEPTH; v++) begin
         t70  = 64'(v) * 64'd70;
         tnum = 64'd10230 + t70;
         if (t70 <= 64'd57288) begin
            r = FULL_ON;
            g = sub_clamp(q_mul(c_g1, ln_rat(tnum, 64'd1023, ln2)), k_g);
         end else begin
            r = to_byte(pow_part(c_r, p_r, t70 - 64'd51150, ln2));
            g = to_byte(pow_part(c_g2, p_g, t70 - 64'd51150, ln2));
         end
         if (t70 >= 64'd57288) begin
            b = FULL_ON;
         end else if (t70 <= 64'd9207) begin
            b = FULL_OFF;
         end else begin
            b = sub_clamp(q_mul(c_b, ln_rat(t70, 64'd1023, ln2)), k_b);
         end
         rom[v] = {r, g, b};
      end
      return rom;
   endfunction

   localparam white_rom_type WHITE_ROM = build_white_rom();

endpackage

// ===== rtl/kcm_front.sv =====
// Front end: accepts items, finds the hue sector and ramp base, forms the level product.
`timescale 1ns / 1ps

module kcm_front (
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              white_mode,
   input  logic [kcm_pkg::KNOB_W-1:0]        color_knob,
   input  logic [kcm_pkg::KNOB_W-1:0]        level_knob,
   input  logic [kcm_pkg::COLOR_W-1:0]       level_floor,
   input  logic [kcm_pkg::COLOR_W-1:0]       level_ceiling,
   input  logic                              q_full,
   output logic                              q_push,
   output kcm_pkg::front_item_type           q_item
);

   logic [12:0]                   six;
   logic [10:0]                   wheel_pos;
   logic [kcm_pkg::KNOB_W-1:0]    fold_dist;
   kcm_pkg::sector_type           sector;
   logic [8:0]                    span;
   logic [kcm_pkg::COLOR_W-1:0]   span_mag;

   // Accept whenever the queue has room
   assign q_push   = req_push && !q_full;
   assign req_full = q_full;

   // Position on the hue wheel: 6v, folded into one sector pair
   always_comb begin
      six = {1'b0, color_knob, 2'b00} + {2'b00, color_knob, 1'b0};
      if (six >= kcm_pkg::HUE_SIX) begin
         wheel_pos = '0;
      end else if (six >= kcm_pkg::HUE_FOUR) begin
         wheel_pos = 11'(six - kcm_pkg::HUE_FOUR);
      end else if (six >= kcm_pkg::HUE_TWO) begin
         wheel_pos = 11'(six - kcm_pkg::HUE_TWO);
      end else begin
         wheel_pos = 11'(six);
      end
      if (wheel_pos >= 11'(kcm_pkg::HUE_STEP)) begin
         fold_dist = 10'(wheel_pos - 11'(kcm_pkg::HUE_STEP));
      end else begin
         fold_dist = 10'(11'(kcm_pkg::HUE_STEP) - wheel_pos);
      end
   end

   // Sector; the top of the knob wraps back to red
   always_comb begin
      if (six >= kcm_pkg::HUE_SIX) begin
         sector = kcm_pkg::SECTOR_RED_YELLOW;
      end else if (six >= kcm_pkg::HUE_FIVE) begin
         sector = kcm_pkg::SECTOR_MAGENTA_RED;
      end else if (six >= kcm_pkg::HUE_FOUR) begin
         sector = kcm_pkg::SECTOR_BLUE_MAGENTA;
      end else if (six >= kcm_pkg::HUE_THREE) begin
         sector = kcm_pkg::SECTOR_CYAN_BLUE;
      end else if (six >= kcm_pkg::HUE_TWO) begin
         sector = kcm_pkg::SECTOR_GREEN_CYAN;
      end else if (six >= kcm_pkg::HUE_STEP) begin
         sector = kcm_pkg::SECTOR_YELLOW_GREEN;
      end else begin
         sector = kcm_pkg::SECTOR_RED_YELLOW;
      end
   end

   // Level: knob times the signed span, kept as magnitude and sign
   always_comb begin
      span     = {1'b0, level_ceiling} - {1'b0, level_floor};
      span_mag = span[8] ? 8'(-span) : span[7:0];
   end

   // Pack the classified item
   always_comb begin
      q_item.white_mode  = white_mode;
      q_item.color_knob  = color_knob;
      q_item.sector      = sector;
      q_item.ramp_base   = kcm_pkg::KNOB_MAX - fold_dist;
      q_item.level_prod  = {8'd0, level_knob} * {10'd0, span_mag};
      q_item.level_neg   = span[8];
      q_item.level_floor = level_floor;
   end

endmodule

// ===== rtl/kcm_queue.sv =====
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps

module kcm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  kcm_pkg::front_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    valid,
   output kcm_pkg::front_item_type pop_item
);

   localparam logic [kcm_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      kcm_pkg::QUEUE_PTR_W'(kcm_pkg::QUEUE_DEPTH - 1);
   localparam logic [kcm_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      kcm_pkg::QUEUE_CNT_W'(kcm_pkg::QUEUE_DEPTH);

   kcm_pkg::front_item_type                slot_ff [kcm_pkg::QUEUE_DEPTH];
   logic [kcm_pkg::QUEUE_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [kcm_pkg::QUEUE_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [kcm_pkg::QUEUE_CNT_W-1:0]        count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign valid    = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue pushed while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid) else $error("queue popped while empty");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL) else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/kcm_back.sv =====
// Back end: table lookup and ramp scaling, then color select, level and changed flag.
`timescale 1ns / 1ps

module kcm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  kcm_pkg::front_item_type         q_item,
   output logic                            q_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [kcm_pkg::COLOR_W-1:0]     rsp_red,
   output logic [kcm_pkg::COLOR_W-1:0]     rsp_green,
   output logic [kcm_pkg::COLOR_W-1:0]     rsp_blue,
   output logic [kcm_pkg::COLOR_W-1:0]     rsp_level,
   output logic                            rsp_changed
);

   // Lookup stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_mode_ff, s1_mode_in;
   kcm_pkg::sector_type           s1_sector_ff, s1_sector_in;
   logic [kcm_pkg::RGB_W-1:0]     s1_rom_ff, s1_rom_in;
   logic [kcm_pkg::COLOR_W-1:0]   s1_ramp_ff, s1_ramp_in;
   logic [kcm_pkg::COLOR_W-1:0]   s1_lvl_q_ff, s1_lvl_q_in;
   logic                          s1_neg_ff, s1_neg_in;
   logic [kcm_pkg::COLOR_W-1:0]   s1_floor_ff, s1_floor_in;

   // Result register; it also holds the previous result for the changed flag
   logic                          out_valid_ff, out_valid_in;
   logic                          seen_any_ff, seen_any_in;
   logic [kcm_pkg::COLOR_W-1:0]   red_ff, red_in;
   logic [kcm_pkg::COLOR_W-1:0]   green_ff, green_in;
   logic [kcm_pkg::COLOR_W-1:0]   blue_ff, blue_in;
   logic [kcm_pkg::COLOR_W-1:0]   level_ff, level_in;
   logic                          changed_ff, changed_in;

   logic                          out_ready;
   logic                          s1_ready;
   logic                          out_load;
   logic [kcm_pkg::PROD_W-1:0]    ramp_prod;
   logic [kcm_pkg::COLOR_W-1:0]   hue_r, hue_g, hue_b;
   logic [kcm_pkg::COLOR_W-1:0]   col_r, col_g, col_b;

   // Stage handshake: a stage loads when it is empty or its item moves on
   assign out_ready = !out_valid_ff || rsp_pop;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign out_load  = s1_valid_ff && out_ready;
   assign q_pop     = q_valid && s1_ready;

   // Lookup stage: read the table, scale the ramp and the level
   always_comb begin
      ramp_prod    = {q_item.ramp_base, 8'd0} - {8'd0, q_item.ramp_base};
      s1_valid_in  = s1_ready ? q_valid : s1_valid_ff;
      s1_mode_in   = q_item.white_mode;
      s1_sector_in = q_item.sector;
      s1_rom_in    = kcm_pkg::WHITE_ROM[q_item.color_knob];
      s1_ramp_in   = kcm_pkg::div_by_1023(ramp_prod);
      s1_lvl_q_in  = kcm_pkg::div_by_1023(q_item.level_prod);
      s1_neg_in    = q_item.level_neg;
      s1_floor_in  = q_item.level_floor;
   end

   // Hue wheel color from the sector
   always_comb begin
      case (s1_sector_ff)
         kcm_pkg::SECTOR_RED_YELLOW: begin
            hue_r = kcm_pkg::FULL_ON;  hue_g = s1_ramp_ff;       hue_b = kcm_pkg::FULL_OFF;
         end
         kcm_pkg::SECTOR_YELLOW_GREEN: begin
            hue_r = s1_ramp_ff;        hue_g = kcm_pkg::FULL_ON;  hue_b = kcm_pkg::FULL_OFF;
         end
         kcm_pkg::SECTOR_GREEN_CYAN: begin
            hue_r = kcm_pkg::FULL_OFF; hue_g = kcm_pkg::FULL_ON;  hue_b = s1_ramp_ff;
         end
         kcm_pkg::SECTOR_CYAN_BLUE: begin
            hue_r = kcm_pkg::FULL_OFF; hue_g = s1_ramp_ff;       hue_b = kcm_pkg::FULL_ON;
         end
         kcm_pkg::SECTOR_BLUE_MAGENTA: begin
            hue_r = s1_ramp_ff;        hue_g = kcm_pkg::FULL_OFF; hue_b = kcm_pkg::FULL_ON;
         end
         default: begin
            hue_r = kcm_pkg::FULL_ON;  hue_g = kcm_pkg::FULL_OFF; hue_b = s1_ramp_ff;
         end
      endcase
   end

   // Result: pick the color, apply the level sign, compare with the last result
   always_comb begin
      if (s1_mode_ff) begin
         col_r = s1_rom_ff[23:16];
         col_g = s1_rom_ff[15:8];
         col_b = s1_rom_ff[7:0];
      end else begin
         col_r = hue_r;
         col_g = hue_g;
         col_b = hue_b;
      end
      red_in       = col_r;
      green_in     = col_g;
      blue_in      = col_b;
      level_in     = s1_neg_ff ? s1_floor_ff - s1_lvl_q_ff : s1_floor_ff + s1_lvl_q_ff;
      changed_in   = !seen_any_ff || (col_r != red_ff) || (col_g != green_ff)
                     || (col_b != blue_ff) || (level_in != level_ff);
      out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;
      seen_any_in  = seen_any_ff || out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seen_any_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         seen_any_ff  <= seen_any_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_mode_ff   <= s1_mode_in;
         s1_sector_ff <= s1_sector_in;
         s1_rom_ff    <= s1_rom_in;
         s1_ramp_ff   <= s1_ramp_in;
         s1_lvl_q_ff  <= s1_lvl_q_in;
         s1_neg_ff    <= s1_neg_in;
         s1_floor_ff  <= s1_floor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         level_ff   <= level_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_level   = level_ff;
   assign rsp_changed = changed_ff;

`ifndef SYNTHESIS
   a_first_result_changed: assert property (@(posedge clock) disable iff (reset)
      $rose(seen_any_ff) |-> out_valid_ff && changed_ff)
      else $error("first result after reset not flagged as changed");
   a_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff)
      else $error("lookup stage dropped an item while stalled");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty
         && $stable({rsp_red, rsp_green, rsp_blue, rsp_level, rsp_changed}))
      else $error("waiting result changed before it was popped");
`endif

endmodule

// ===== rtl/knob_to_led_color_mapper.sv =====
// Top level of the knob to LED color mapper: register port, front end, queue, back end.
//
// Usage:
//   Input items (white_mode, color_knob, level_knob) enter on req_push when
//   req_full is low. Results (red, green, blue, level, changed) wait on the
//   rsp_ ports while rsp_empty is low and leave on rsp_pop.
//   The register port sets the level for knob zero (address 0, reset 64) and
//   for knob full scale (address 4, reset 255); write them only while idle.
// Timing:
//   An accepted item passes the queue slot, the table lookup stage and the
//   result register before it is visible as a result. The block takes one
//   item every cycle while results are popped; that rate is set by the table
//   lookup and the two reciprocal multiplies that run side by side in the
//   lookup stage. A stalled result holds the lookup stage, then the
//   four-entry queue fills and req_full rises; no item is dropped.
// Reset:
//   Clears the queue, both stages and the registers to their reset values.
//   The first result after reset always reports changed. The color
//   temperature table is a constant and needs no fill.
`timescale 1ns / 1ps

module knob_to_led_color_mapper (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_white_mode,
   input  logic [kcm_pkg::KNOB_W-1:0]         req_color_knob,
   input  logic [kcm_pkg::KNOB_W-1:0]         req_level_knob,
   // result items
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [kcm_pkg::COLOR_W-1:0]        rsp_red,
   output logic [kcm_pkg::COLOR_W-1:0]        rsp_green,
   output logic [kcm_pkg::COLOR_W-1:0]        rsp_blue,
   output logic [kcm_pkg::COLOR_W-1:0]        rsp_level,
   output logic                               rsp_changed,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kcm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [kcm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [kcm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [kcm_pkg::COLOR_W-1:0] floor_ff, floor_in;
   logic [kcm_pkg::COLOR_W-1:0] ceiling_ff, ceiling_in;
   logic                        csr_write;
   logic [0:0]                  csr_index;

   logic                        q_full;
   logic                        q_push;
   logic                        q_valid;
   logic                        q_pop;
   kcm_pkg::front_item_type     push_item;
   kcm_pkg::front_item_type     pop_item;

   // Register port: always ready, write in the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      floor_in   = floor_ff;
      ceiling_in = ceiling_ff;
      if (csr_write) begin
         case (csr_index)
            kcm_pkg::CSR_FLOOR:   floor_in   = csr_pwdata[kcm_pkg::COLOR_W-1:0];
            kcm_pkg::CSR_CEILING: ceiling_in = csr_pwdata[kcm_pkg::COLOR_W-1:0];
            default: begin
               floor_in   = floor_ff;
               ceiling_in = ceiling_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= kcm_pkg::FLOOR_RESET;
         ceiling_ff <= kcm_pkg::CEILING_RESET;
      end else begin
         floor_ff   <= floor_in;
         ceiling_ff <= ceiling_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         kcm_pkg::CSR_FLOOR:   csr_prdata = {24'd0, floor_ff};
         kcm_pkg::CSR_CEILING: csr_prdata = {24'd0, ceiling_ff};
         default:              csr_prdata = '0;
      endcase
   end

   kcm_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .white_mode    (req_white_mode),
      .color_knob    (req_color_knob),
      .level_knob    (req_level_knob),
      .level_floor   (floor_ff),
      .level_ceiling (ceiling_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   kcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   kcm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (pop_item),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_level   (rsp_level),
      .rsp_changed (rsp_changed)
   );

endmodule
